// ===== hw/rtl/video_register_write_port_top_defines.svh =====
// ----------------------------------------------------------------------------
// Video register write port: assertion macros
// Shared concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_WRITE_PORT_TOP_DEFINES_SVH
`define VIDEO_REGISTER_WRITE_PORT_TOP_DEFINES_SVH

`ifndef SYNTH
`define VRWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vrwp assertion failed");
`define VRWP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vrwp assertion failed");
`else
`define VRWP_ASSERT_IMP(lbl, ante, cons)
`define VRWP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/vrwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Video register write port package
// Register offsets, effect kinds, register selects and the result type.
// ----------------------------------------------------------------------------
package vrwp_pkg;

  typedef enum logic [2:0] {
    EFF_NONE    = 3'd0,
    EFF_VIDEO   = 3'd1,
    EFF_SPRITE  = 3'd2,
    EFF_PALETTE = 3'd3,
    EFF_REG     = 3'd4
  } effect_e;

  typedef struct packed {
    effect_e     kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  sel;
    logic [15:0] value;
    logic        last;
  } res_t;

  localparam logic [5:0] OFF_DISP_CTRL   = 6'h00;
  localparam logic [5:0] OFF_SPR_ADDR_LO = 6'h02;
  localparam logic [5:0] OFF_SPR_ADDR_HI = 6'h03;
  localparam logic [5:0] OFF_SPR_DATA    = 6'h04;
  localparam logic [5:0] OFF_BG1_H       = 6'h0d;
  localparam logic [5:0] OFF_BG1_V       = 6'h0e;
  localparam logic [5:0] OFF_BG2_H       = 6'h0f;
  localparam logic [5:0] OFF_BG2_V       = 6'h10;
  localparam logic [5:0] OFF_BG3_H       = 6'h11;
  localparam logic [5:0] OFF_BG3_V       = 6'h12;
  localparam logic [5:0] OFF_VID_CTRL    = 6'h15;
  localparam logic [5:0] OFF_VID_ADDR_LO = 6'h16;
  localparam logic [5:0] OFF_VID_ADDR_HI = 6'h17;
  localparam logic [5:0] OFF_VID_DATA_LO = 6'h18;
  localparam logic [5:0] OFF_VID_DATA_HI = 6'h19;
  localparam logic [5:0] OFF_ROT_A       = 6'h1b;
  localparam logic [5:0] OFF_ROT_B       = 6'h1c;
  localparam logic [5:0] OFF_ROT_C       = 6'h1d;
  localparam logic [5:0] OFF_ROT_D       = 6'h1e;
  localparam logic [5:0] OFF_ROT_X       = 6'h1f;
  localparam logic [5:0] OFF_ROT_Y       = 6'h20;
  localparam logic [5:0] OFF_PAL_ADDR    = 6'h21;
  localparam logic [5:0] OFF_PAL_DATA    = 6'h22;
  localparam logic [5:0] OFF_FIX_COLOUR  = 6'h32;

  localparam logic [3:0] SEL_DISP     = 4'd0;
  localparam logic [3:0] SEL_FIX      = 4'd1;
  localparam logic [3:0] SEL_ROT_A    = 4'd2;
  localparam logic [3:0] SEL_ROT_OFSH = 4'd8;
  localparam logic [3:0] SEL_ROT_OFSV = 4'd9;
  localparam logic [3:0] SEL_BG1_H    = 4'd10;
  localparam logic [3:0] SEL_BG1_V    = 4'd11;

  localparam logic [7:0]  DISP_MASK      = 8'h8f;
  localparam logic [15:0] SPR_HIGH_BASE  = 16'h0200;
  localparam logic [15:0] VID_STEP_ONE   = 16'd1;
  localparam logic [15:0] VID_STEP_ROW   = 16'd32;
  localparam logic [15:0] VID_STEP_BLOCK = 16'd128;

endpackage

// ===== hw/rtl/vrwp_exec.sv =====
// ----------------------------------------------------------------------------
// Video register write port: write decode
// Holds pointers, latches and phase bits; decodes one write into results.
// ----------------------------------------------------------------------------
module vrwp_exec import vrwp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [5:0] off_i,
  input  logic [7:0] data_i,
  output res_t       res0_o,
  output res_t       res1_o,
  output logic       two_o
);

  logic [9:0]  spr_ptr_q,   spr_ptr_d;
  logic [7:0]  spr_latch_q, spr_latch_d;
  logic [15:0] vid_ptr_q,   vid_ptr_d;
  logic [2:0]  vid_ctl_q,   vid_ctl_d;
  logic [7:0]  pal_ptr_q,   pal_ptr_d;
  logic        pal_phase_q, pal_phase_d;
  logic [14:0] fix_q,       fix_d;
  logic [7:0]  rot_latch_q, rot_latch_d;
  logic [7:0]  scr_latch_q, scr_latch_d;
  logic [2:0]  fine_q [3];
  logic [2:0]  fine_d [3];

  logic [1:0]  bg;
  logic [15:0] hi;
  logic [15:0] vid_step;
  logic [14:0] fix_new;

  always_comb begin
    case (off_i)
      OFF_BG2_H, OFF_BG2_V: bg = 2'd1;
      OFF_BG3_H, OFF_BG3_V: bg = 2'd2;
      default:              bg = 2'd0;
    endcase
    case (vid_ctl_q[1:0])
      2'd0:    vid_step = VID_STEP_ONE;
      2'd1:    vid_step = VID_STEP_ROW;
      default: vid_step = VID_STEP_BLOCK;
    endcase
  end

  assign hi = {data_i, 8'h00};

  always_comb begin
    res0_o      = '0;
    res0_o.last = 1'b1;
    res1_o      = '0;
    res1_o.last = 1'b1;
    two_o       = 1'b0;
    spr_ptr_d   = spr_ptr_q;
    spr_latch_d = spr_latch_q;
    vid_ptr_d   = vid_ptr_q;
    vid_ctl_d   = vid_ctl_q;
    pal_ptr_d   = pal_ptr_q;
    pal_phase_d = pal_phase_q;
    fix_d       = fix_q;
    rot_latch_d = rot_latch_q;
    scr_latch_d = scr_latch_q;
    fine_d      = fine_q;
    fix_new     = fix_q;
    case (off_i)
      OFF_DISP_CTRL: begin
        res0_o.kind  = EFF_REG;
        res0_o.sel   = SEL_DISP;
        res0_o.value = {8'h00, data_i & DISP_MASK};
      end
      OFF_SPR_ADDR_LO: spr_ptr_d = {spr_ptr_q[9], data_i, 1'b0};
      OFF_SPR_ADDR_HI: spr_ptr_d = {data_i[0], spr_ptr_q[8:0]};
      OFF_SPR_DATA: begin
        spr_ptr_d = spr_ptr_q + 10'd1;
        if (spr_ptr_q[9]) begin
          res0_o.kind = EFF_SPRITE;
          res0_o.addr = SPR_HIGH_BASE | {11'd0, spr_ptr_q[4:0]};
          res0_o.data = data_i;
        end else if (!spr_ptr_q[0]) begin
          spr_latch_d = data_i;
        end else begin
          res0_o.kind = EFF_SPRITE;
          res0_o.addr = {6'd0, spr_ptr_q[9:1], 1'b0};
          res0_o.data = spr_latch_q;
          res0_o.last = 1'b0;
          res1_o.kind = EFF_SPRITE;
          res1_o.addr = {6'd0, spr_ptr_q};
          res1_o.data = data_i;
          two_o       = 1'b1;
        end
      end
      OFF_BG1_H, OFF_BG2_H, OFF_BG3_H: begin
        res0_o.kind  = EFF_REG;
        res0_o.sel   = SEL_BG1_H + {1'b0, bg, 1'b0};
        res0_o.value = {data_i, scr_latch_q[7:3], fine_q[bg]};
        fine_d[bg]   = data_i[2:0];
        scr_latch_d  = data_i;
        if (bg == 2'd0) begin
          res0_o.last  = 1'b0;
          res1_o.kind  = EFF_REG;
          res1_o.sel   = SEL_ROT_OFSH;
          res1_o.value = hi | {8'h00, rot_latch_q};
          rot_latch_d  = data_i;
          two_o        = 1'b1;
        end
      end
      OFF_BG1_V, OFF_BG2_V, OFF_BG3_V: begin
        res0_o.kind  = EFF_REG;
        res0_o.sel   = SEL_BG1_V + {1'b0, bg, 1'b0};
        res0_o.value = {data_i, scr_latch_q};
        scr_latch_d  = data_i;
        if (bg == 2'd0) begin
          res0_o.last  = 1'b0;
          res1_o.kind  = EFF_REG;
          res1_o.sel   = SEL_ROT_OFSV;
          res1_o.value = hi | {8'h00, rot_latch_q};
          rot_latch_d  = data_i;
          two_o        = 1'b1;
        end
      end
      OFF_VID_CTRL:    vid_ctl_d = {data_i[7], data_i[1:0]};
      OFF_VID_ADDR_LO: vid_ptr_d = {vid_ptr_q[15:8], data_i};
      OFF_VID_ADDR_HI: vid_ptr_d = {data_i, vid_ptr_q[7:0]};
      OFF_VID_DATA_LO: begin
        res0_o.kind = EFF_VIDEO;
        res0_o.addr = {vid_ptr_q[14:0], 1'b0};
        res0_o.data = data_i;
        if (!vid_ctl_q[2]) vid_ptr_d = vid_ptr_q + vid_step;
      end
      OFF_VID_DATA_HI: begin
        res0_o.kind = EFF_VIDEO;
        res0_o.addr = {vid_ptr_q[14:0], 1'b1};
        res0_o.data = data_i;
        if (vid_ctl_q[2]) vid_ptr_d = vid_ptr_q + vid_step;
      end
      OFF_ROT_A, OFF_ROT_B, OFF_ROT_C, OFF_ROT_D, OFF_ROT_X, OFF_ROT_Y: begin
        res0_o.kind  = EFF_REG;
        res0_o.sel   = SEL_ROT_A + 4'(off_i - OFF_ROT_A);
        res0_o.value = hi | {8'h00, rot_latch_q};
        rot_latch_d  = data_i;
      end
      OFF_PAL_ADDR: begin
        pal_ptr_d   = data_i;
        pal_phase_d = 1'b0;
      end
      OFF_PAL_DATA: begin
        res0_o.kind = EFF_PALETTE;
        res0_o.addr = {7'd0, pal_ptr_q, pal_phase_q};
        res0_o.data = data_i;
        if (pal_phase_q) pal_ptr_d = pal_ptr_q + 8'd1;
        pal_phase_d = !pal_phase_q;
      end
      OFF_FIX_COLOUR: begin
        if (data_i[5]) fix_new[4:0]   = data_i[4:0];
        if (data_i[6]) fix_new[9:5]   = data_i[4:0];
        if (data_i[7]) fix_new[14:10] = data_i[4:0];
        fix_d        = fix_new;
        res0_o.kind  = EFF_REG;
        res0_o.sel   = SEL_FIX;
        res0_o.value = {1'b0, fix_new};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_ptr_q   <= '0;
      spr_latch_q <= '0;
      vid_ptr_q   <= '0;
      vid_ctl_q   <= '0;
      pal_ptr_q   <= '0;
      pal_phase_q <= 1'b0;
      fix_q       <= '0;
      rot_latch_q <= '0;
      scr_latch_q <= '0;
      fine_q      <= '{default: '0};
    end else if (take_i) begin
      spr_ptr_q   <= spr_ptr_d;
      spr_latch_q <= spr_latch_d;
      vid_ptr_q   <= vid_ptr_d;
      vid_ctl_q   <= vid_ctl_d;
      pal_ptr_q   <= pal_ptr_d;
      pal_phase_q <= pal_phase_d;
      fix_q       <= fix_d;
      rot_latch_q <= rot_latch_d;
      scr_latch_q <= scr_latch_d;
      fine_q      <= fine_d;
    end
  end

`include "video_register_write_port_top_defines.svh"

  `VRWP_ASSERT_NEXT(a_spr_ptr_step, take_i && (off_i == OFF_SPR_DATA), spr_ptr_q == $past(spr_ptr_q) + 10'd1)
  `VRWP_ASSERT_NEXT(a_pal_phase_flip, take_i && (off_i == OFF_PAL_DATA), pal_phase_q != $past(pal_phase_q))
  `VRWP_ASSERT_IMP(a_two_source, two_o, (off_i == OFF_SPR_DATA) || (off_i == OFF_BG1_H) || (off_i == OFF_BG1_V))

endmodule

// ===== hw/rtl/vrwp_outq.sv =====
// ----------------------------------------------------------------------------
// Video register write port: result queue
// Two-entry result register; takes one or two, drains one a cycle on pop_i.
// ----------------------------------------------------------------------------
module vrwp_outq import vrwp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_i,
  input  logic two_i,
  input  res_t res0_i,
  input  res_t res1_i,
  input  logic pop_i,
  output logic room_o,
  output logic head_valid_o,
  output res_t head_o
);

  logic v0_q, v0_d, v1_q, v1_d;
  res_t s0_q, s0_d, s1_q, s1_d;
  logic keep0_v, keep1_v, do_pop, push;
  res_t keep0;

  assign do_pop  = v0_q && pop_i;
  assign keep0_v = do_pop ? v1_q : v0_q;
  assign keep0   = do_pop ? s1_q : s0_q;
  assign keep1_v = do_pop ? 1'b0 : v1_q;
  assign room_o  = !keep0_v || (!keep1_v && !two_i);
  assign push    = req_i && room_o;

  always_comb begin
    v0_d = keep0_v;
    s0_d = keep0;
    v1_d = keep1_v;
    s1_d = s1_q;
    if (push) begin
      if (!keep0_v) begin
        v0_d = 1'b1;
        s0_d = res0_i;
        v1_d = two_i;
        s1_d = res1_i;
      end else begin
        v1_d = 1'b1;
        s1_d = res0_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign head_valid_o = v0_q;
  assign head_o       = s0_q;

`include "video_register_write_port_top_defines.svh"

  `VRWP_ASSERT_IMP(a_slot_order, v1_q, v0_q)
  `VRWP_ASSERT_IMP(a_pair_held, v0_q && !s0_q.last, v1_q && s1_q.last)

endmodule

// ===== hw/rtl/video_register_write_port_top.sv =====
// ----------------------------------------------------------------------------
// Video register write port
// One CPU register write in, its memory-write and register-update results out.
// ----------------------------------------------------------------------------
// Each write passes an input register, one decode step and a two-entry result
// register; once it leaves the input register, its first result is registered
// in the result register and shown on the output. A write giving one result
// sustains one write per cycle while the output is not held back; sprite
// paired-word writes and first-background scroll writes give two results,
// which leave one after the other as the channel moves one result per cycle;
// such a write waits in the input register until the result register is empty.
module video_register_write_port_top import vrwp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [5:0] reg_offset, [13:6] write_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] mem_address, [23:16] mem_data, [27:24] reg_select, [43:28] reg_value
  output logic [47:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,  // [2:0] effect_kind
  output logic        m_axis_tlast_o   // last_result
);

  logic       in_valid_q;
  logic [5:0] in_off_q;
  logic [7:0] in_data_q;
  logic       take, room, two;
  res_t       res0, res1, head;

  assign take            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_off_q  <= s_axis_tdata_i[5:0];
      in_data_q <= s_axis_tdata_i[13:6];
    end
  end

  vrwp_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .off_i  (in_off_q),
    .data_i (in_data_q),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (two)
  );

  vrwp_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (in_valid_q),
    .two_i        (two),
    .res0_i       (res0),
    .res1_i       (res1),
    .pop_i        (m_axis_tready_i),
    .room_o       (room),
    .head_valid_o (m_axis_tvalid_o),
    .head_o       (head)
  );

  assign m_axis_tdata_o = {4'h0, head.value, head.sel, head.data, head.addr};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule
